FILE: src/fhc_pkg.sv
// ---------------------------------------------------------------------------
// fhc_pkg
// Types, codes and helper functions shared by the frame header checker.
// ---------------------------------------------------------------------------
package fhc_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hff;
    localparam logic [7:0] SYNC_SECOND = 8'hf8;
    localparam logic [7:0] CRC8_POLY   = 8'h07;
    localparam logic [7:0] CHAN_MAX    = 8'ha0;
    localparam logic [7:0] BS_ONE_XTRA = 8'h60;
    localparam logic [7:0] BS_TWO_XTRA = 8'h70;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_BAD_SYNC = 2'd1;
    localparam logic [1:0] VERDICT_RESERVED = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CRC  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } fhc_in_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [4:0] header_length;
    } fhc_out_t;

    // handshake status from the checker to the stages around it
    typedef struct packed {
        logic take;
        logic emit;
    } fhc_ctl_t;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC8_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // bytes of the coded frame number, from its lead byte
    function automatic logic [3:0] lead_length(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd1;
        run = b[7];
        for (int i = 6; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

FILE: src/fhc_in_stage.sv
// ---------------------------------------------------------------------------
// fhc_in_stage
// Input register: holds one accepted byte for the header checker.
// ---------------------------------------------------------------------------
module fhc_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fhc_pkg::fhc_in_t s_data,
    input  logic             take,
    output logic             item_valid,
    output fhc_pkg::fhc_in_t item
);
    import fhc_pkg::*;

    logic    valid_reg;
    fhc_in_t data_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

FILE: src/fhc_step.sv
// ---------------------------------------------------------------------------
// fhc_step
// Header parse state, field checks, length bookkeeping and running CRC-8.
// ---------------------------------------------------------------------------
module fhc_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  fhc_pkg::fhc_in_t  item,
    input  logic              out_free,
    output fhc_pkg::fhc_ctl_t ctl,
    output fhc_pkg::fhc_out_t result
);
    import fhc_pkg::*;

    logic       active_reg, active_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] srb_reg, srb_next;
    logic [4:0] exp_reg, exp_next;
    logic [7:0] crc_reg, crc_next;

    logic       act;
    logic [4:0] pos;
    logic [7:0] srb;
    logic [4:0] exp_len;
    logic [7:0] crc_upd;
    logic [4:0] consumed;
    logic [4:0] len;
    logic [7:0] b;
    logic       emit;
    logic [1:0] verdict;
    logic       take;

    always_comb begin
        b        = item.data_byte;
        act      = item.start_req || active_reg;
        pos      = item.start_req ? 5'd0 : pos_reg;
        srb      = item.start_req ? 8'd0 : srb_reg;
        exp_len  = item.start_req ? 5'd0 : exp_reg;
        crc_upd  = crc8_next(item.start_req ? 8'd0 : crc_reg, b);
        consumed = pos + 5'd1;
        emit     = 1'b0;
        verdict  = VERDICT_OK;
        len      = 5'd5 + {1'b0, lead_length(b)};
        if ((srb & 8'hf0) == BS_ONE_XTRA) begin
            len = len + 5'd1;
        end else if ((srb & 8'hf0) == BS_TWO_XTRA) begin
            len = len + 5'd2;
        end
        if (srb[3:0] == 4'hc) begin
            len = len + 5'd1;
        end else if (srb[3:2] == 2'b11) begin
            len = len + 5'd2;
        end
        srb_next = srb;
        exp_next = exp_len;
        case (pos)
            5'd0: begin
                if (b != SYNC_FIRST) begin
                    emit    = 1'b1;
                    verdict = VERDICT_BAD_SYNC;
                end
            end
            5'd1: begin
                if (b != SYNC_SECOND) begin
                    emit    = 1'b1;
                    verdict = VERDICT_BAD_SYNC;
                end
            end
            5'd2: begin
                if ((b[3:0] >= 4'd1 && b[3:0] <= 4'd3) || b[3:0] == 4'hf) begin
                    emit    = 1'b1;
                    verdict = VERDICT_RESERVED;
                end else begin
                    srb_next = b;
                end
            end
            5'd3: begin
                // reserved bit, channel code, sample-size code
                if (b[0] || (b & 8'hf0) > CHAN_MAX || b[3:1] == 3'b011
                        || b[3:1] == 3'b111) begin
                    emit    = 1'b1;
                    verdict = VERDICT_RESERVED;
                end
            end
            5'd4: begin
                exp_next = len;
            end
            default: begin
                if (consumed >= exp_len) begin
                    emit    = 1'b1;
                    verdict = (crc_upd == 8'd0) ? VERDICT_OK : VERDICT_BAD_CRC;
                end
            end
        endcase
        emit = emit && act;

        take        = item_valid && (!emit || out_free);
        active_next = act && !emit;
        pos_next    = emit ? 5'd0 : consumed;
        crc_next    = crc_upd;
        if (!act) begin
            active_next = active_reg;
            pos_next    = pos_reg;
            srb_next    = srb_reg;
            exp_next    = exp_reg;
            crc_next    = crc_reg;
        end
    end

    assign ctl.take             = take;
    assign ctl.emit             = item_valid && emit;
    assign result.verdict       = verdict;
    assign result.header_length = consumed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pos_reg    <= 5'd0;
            srb_reg    <= 8'd0;
            exp_reg    <= 5'd0;
            crc_reg    <= 8'd0;
        end else if (take) begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            srb_reg    <= srb_next;
            exp_reg    <= exp_next;
            crc_reg    <= crc_next;
        end
    end

    // a verdict needs a candidate in progress or starting here
    a_emit_needs_candidate: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> (item.start_req || active_reg))
        else $error("verdict without a candidate");

    // a delivered verdict closes the candidate
    a_verdict_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && emit) |=> (!active_reg && pos_reg == 5'd0))
        else $error("candidate still open after verdict");

    // position never runs past the longest header
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pos_reg <= 5'd16))
        else $error("byte position past longest header");

    // an idle block with no start mark leaves its state alone
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !act) |=> ($stable(active_reg) && $stable(pos_reg)))
        else $error("idle byte changed parse state");

endmodule

FILE: src/fhc_out_stage.sv
// ---------------------------------------------------------------------------
// fhc_out_stage
// Result register: holds one verdict until the downstream side takes it.
// ---------------------------------------------------------------------------
module fhc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  fhc_pkg::fhc_out_t result,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output fhc_pkg::fhc_out_t m_data
);
    import fhc_pkg::*;

    logic     valid_reg;
    fhc_out_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && out_free) begin
            data_reg <= result;
        end
    end

endmodule

FILE: src/flac_frame_header_check_core.sv
// path: a byte is held in the input register; its verdict is registered in the result register and shows on m_data
// throughput: one byte per cycle; a byte that ends a candidate waits only
//   while the result register is full and m_ready is low
// reset: synchronous, active-low aresetn clears both stage valids and the
//   parse state (no candidate open); no clearing pass
// ---------------------------------------------------------------------------
// flac_frame_header_check_core
// Byte-serial FLAC frame header checker: sync, reserved codes, length, CRC-8.
// ---------------------------------------------------------------------------
module flac_frame_header_check_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fhc_pkg::fhc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fhc_pkg::fhc_out_t m_data
);
    import fhc_pkg::*;

    logic      item_valid;
    fhc_in_t   item;
    fhc_ctl_t  ctl;
    fhc_out_t  result;
    logic      out_free;

    fhc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (ctl.take),
        .item_valid (item_valid),
        .item       (item)
    );

    fhc_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .ctl        (ctl),
        .result     (result)
    );

    fhc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctl.emit),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
